// ===== sv/cst_pkg.sv =====
// shared types, constants and character classes for the c subset tokenizer
`default_nettype none

package cst_pkg;

	// longest word or number before it is split
	localparam int MAX_TOKEN_LEN = 63;
	localparam int LEN_W = $clog2(MAX_TOKEN_LEN + 1);

	// result queue geometry
	localparam int FIFO_DEPTH = 4;
	localparam int PTR_W = $clog2(FIFO_DEPTH);
	localparam int CNT_W = $clog2(FIFO_DEPTH + 1);

	// result kinds
	localparam logic [2:0] K_WORD  = 3'd0;
	localparam logic [2:0] K_NUM   = 3'd1;
	localparam logic [2:0] K_PUNCT = 3'd2;
	localparam logic [2:0] K_OTHER = 3'd3;
	localparam logic [2:0] K_END   = 3'd4;
	localparam logic [2:0] K_ERROR = 3'd5;

	// error codes
	localparam logic [1:0] E_NONE    = 2'd0;
	localparam logic [1:0] E_UNTERM  = 2'd1;
	localparam logic [1:0] E_BAD_NUM = 2'd2;

	// scan modes
	typedef enum logic [6:0] {
		M_IDLE  = 7'b0000001,
		M_WORD  = 7'b0000010,
		M_NUM   = 7'b0000100,
		M_OPS   = 7'b0001000,
		M_LINE  = 7'b0010000,
		M_BLOCK = 7'b0100000,
		M_ERR   = 7'b1000000
	} mode_t;

	// one result entry
	typedef struct packed {
		logic [2:0] kind;
		logic [7:0] text;
		logic       tend;
		logic [1:0] err;
		logic       last;
	} res_t;

	function automatic logic is_alpha(input logic [7:0] c);
		return (c inside {[8'h61:8'h7a], [8'h41:8'h5a], 8'h5f});
	endfunction

	function automatic logic is_digit(input logic [7:0] c);
		return (c inside {[8'h30:8'h39]});
	endfunction

	function automatic logic is_space(input logic [7:0] c);
		return (c inside {8'h20, 8'h09, 8'h0a, 8'h0d});
	endfunction

	// / = ! < > & |
	function automatic logic is_opstart(input logic [7:0] c);
		return (c inside {8'h2f, 8'h3d, 8'h21, 8'h3c, 8'h3e, 8'h26, 8'h7c});
	endfunction

	// + - * % ( ) { } ; ,
	function automatic logic is_single(input logic [7:0] c);
		return (c inside {8'h2b, 8'h2d, 8'h2a, 8'h25, 8'h28, 8'h29,
			8'h7b, 8'h7d, 8'h3b, 8'h2c});
	endfunction

	// == != <= >= && ||
	function automatic logic two_char(input logic [7:0] p, input logic [7:0] c);
		return ((c == 8'h3d) && (p inside {8'h3d, 8'h21, 8'h3c, 8'h3e})) ||
			((p == 8'h26) && (c == 8'h26)) || ((p == 8'h7c) && (c == 8'h7c));
	endfunction

	function automatic res_t mk_res(input logic [2:0] kind, input logic [7:0] text,
		input logic tend, input logic [1:0] err);
		res_t r;
		r.kind = kind;
		r.text = text;
		r.tend = tend;
		r.err  = err;
		r.last = 1'b0;
		return r;
	endfunction

	// a lone operator start: & and | count as other characters
	function automatic res_t lone_res(input logic [7:0] p);
		return mk_res(((p == 8'h26) || (p == 8'h7c)) ? K_OTHER : K_PUNCT, p, 1'b1, E_NONE);
	endfunction

endpackage

`default_nettype wire

// ===== sv/c_subset_tokenizer_top.sv =====
// c subset tokenizer: scan state, per-byte decision logic and result queue
// The results of a request are written into the result queue as the request is accepted.
// Throughput: one request per cycle while each request yields at most one result and out_ready stays high;
// a request that yields two results puts both into the queue, which the single result port offers one at a time.
// The four-entry result queue sets this: in_ready is high while it has room for two.
// Reset (arst_n low, asynchronous): scan state idle, nothing held, queue empty.
`default_nettype none

module c_subset_tokenizer_top
	import cst_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       in_valid,
	output logic            in_ready,
	input  wire logic [7:0] ch,
	input  wire logic       end_of_input,
	output logic            out_valid,
	input  wire logic       out_ready,
	output logic [2:0]      kind,
	output logic [7:0]      text_byte,
	output logic            token_end,
	output logic [1:0]      error_code,
	output logic            last
);

	mode_t            mode_q, mode_d;
	logic [7:0]       pend_byte_q, pend_byte_d;
	logic             pend_valid_q, pend_valid_d;
	logic [LEN_W-1:0] len_q, len_d;

	mode_t            st_mode;
	logic [7:0]       st_byte;
	logic             st_valid;
	logic [LEN_W-1:0] st_len;
	logic             st_emit;
	res_t             st_res;

	res_t       r0, r1, r0_l, r1_l;
	logic [1:0] res_n;
	logic [1:0] push_n;
	logic       in_fire, pop;
	logic       len_room;

	res_t             fifo_q [FIFO_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	assign in_ready = (count_q <= CNT_W'(FIFO_DEPTH - 2));
	assign in_fire  = in_valid && in_ready;
	assign len_room = (len_q < LEN_W'(MAX_TOKEN_LEN));

	// fresh token start from the current byte
	always_comb begin
		st_mode  = M_IDLE;
		st_byte  = 8'h00;
		st_valid = 1'b0;
		st_len   = '0;
		st_emit  = 1'b0;
		st_res   = mk_res(K_OTHER, ch, 1'b1, E_NONE);
		if (is_space(ch)) begin
			st_mode = M_IDLE;
		end else if (is_alpha(ch)) begin
			st_mode  = M_WORD;
			st_byte  = ch;
			st_valid = 1'b1;
			st_len   = LEN_W'(1);
		end else if (is_digit(ch)) begin
			st_mode  = M_NUM;
			st_byte  = ch;
			st_valid = 1'b1;
			st_len   = LEN_W'(1);
		end else if (is_opstart(ch)) begin
			st_mode  = M_OPS;
			st_byte  = ch;
			st_valid = 1'b1;
		end else if (is_single(ch)) begin
			st_emit = 1'b1;
			st_res  = mk_res(K_PUNCT, ch, 1'b1, E_NONE);
		end else begin
			st_emit = 1'b1;
		end
	end

	// next state and results for one request
	always_comb begin
		mode_d       = mode_q;
		pend_byte_d  = pend_byte_q;
		pend_valid_d = pend_valid_q;
		len_d        = len_q;
		r0           = mk_res(K_END, 8'h00, 1'b1, E_NONE);
		r1           = mk_res(K_END, 8'h00, 1'b1, E_NONE);
		res_n        = 2'd0;
		if (end_of_input) begin
			mode_d       = M_IDLE;
			pend_byte_d  = 8'h00;
			pend_valid_d = 1'b0;
			len_d        = '0;
			case (mode_q)
				M_WORD: begin
					r0    = mk_res(K_WORD, pend_byte_q, 1'b1, E_NONE);
					res_n = 2'd2;
				end
				M_NUM: begin
					r0    = mk_res(K_NUM, pend_byte_q, 1'b1, E_NONE);
					res_n = 2'd2;
				end
				M_OPS: begin
					r0    = lone_res(pend_byte_q);
					res_n = 2'd2;
				end
				M_BLOCK: begin
					r0    = mk_res(K_ERROR, 8'h00, 1'b1, E_UNTERM);
					res_n = 2'd1;
				end
				M_ERR: begin
					res_n = 2'd0;
				end
				default: begin
					res_n = 2'd1;
				end
			endcase
		end else begin
			case (mode_q)
				M_WORD: begin
					if ((is_alpha(ch) || is_digit(ch)) && len_room) begin
						r0          = mk_res(K_WORD, pend_byte_q, 1'b0, E_NONE);
						res_n       = 2'd1;
						pend_byte_d = ch;
						len_d       = len_q + LEN_W'(1);
					end else begin
						r0           = mk_res(K_WORD, pend_byte_q, 1'b1, E_NONE);
						r1           = st_res;
						res_n        = st_emit ? 2'd2 : 2'd1;
						mode_d       = st_mode;
						pend_byte_d  = st_byte;
						pend_valid_d = st_valid;
						len_d        = st_len;
					end
				end
				M_NUM: begin
					if (is_digit(ch) && len_room) begin
						r0          = mk_res(K_NUM, pend_byte_q, 1'b0, E_NONE);
						res_n       = 2'd1;
						pend_byte_d = ch;
						len_d       = len_q + LEN_W'(1);
					end else if (is_alpha(ch)) begin
						r0           = mk_res(K_ERROR, 8'h00, 1'b1, E_BAD_NUM);
						res_n        = 2'd1;
						mode_d       = M_ERR;
						pend_byte_d  = 8'h00;
						pend_valid_d = 1'b0;
						len_d        = '0;
					end else begin
						r0           = mk_res(K_NUM, pend_byte_q, 1'b1, E_NONE);
						r1           = st_res;
						res_n        = st_emit ? 2'd2 : 2'd1;
						mode_d       = st_mode;
						pend_byte_d  = st_byte;
						pend_valid_d = st_valid;
						len_d        = st_len;
					end
				end
				M_OPS: begin
					pend_byte_d  = 8'h00;
					pend_valid_d = 1'b0;
					len_d        = '0;
					if (two_char(pend_byte_q, ch)) begin
						r0     = mk_res(K_PUNCT, pend_byte_q, 1'b0, E_NONE);
						r1     = mk_res(K_PUNCT, ch, 1'b1, E_NONE);
						res_n  = 2'd2;
						mode_d = M_IDLE;
					end else if ((pend_byte_q == 8'h2f) && (ch == 8'h2f)) begin
						mode_d = M_LINE;
					end else if ((pend_byte_q == 8'h2f) && (ch == 8'h2a)) begin
						mode_d = M_BLOCK;
					end else begin
						r0           = lone_res(pend_byte_q);
						r1           = st_res;
						res_n        = st_emit ? 2'd2 : 2'd1;
						mode_d       = st_mode;
						pend_byte_d  = st_byte;
						pend_valid_d = st_valid;
						len_d        = st_len;
					end
				end
				M_LINE: begin
					if (ch == 8'h0a) begin
						mode_d = M_IDLE;
					end
				end
				M_BLOCK: begin
					// pending marks a star just seen
					if (pend_valid_q && (ch == 8'h2f)) begin
						mode_d       = M_IDLE;
						pend_byte_d  = 8'h00;
						pend_valid_d = 1'b0;
						len_d        = '0;
					end else if (ch == 8'h2a) begin
						pend_byte_d  = 8'h2a;
						pend_valid_d = 1'b1;
					end else begin
						pend_byte_d  = 8'h00;
						pend_valid_d = 1'b0;
					end
				end
				M_ERR: begin
					res_n = 2'd0;
				end
				default: begin
					r0           = st_res;
					res_n        = st_emit ? 2'd1 : 2'd0;
					mode_d       = st_mode;
					pend_byte_d  = st_byte;
					pend_valid_d = st_valid;
					len_d        = st_len;
				end
			endcase
		end
	end

	// mark the final result of the request
	always_comb begin
		r0_l      = r0;
		r1_l      = r1;
		r0_l.last = (res_n == 2'd1);
		r1_l.last = 1'b1;
	end

	assign push_n = in_fire ? res_n : 2'd0;

	// scan state registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q       <= M_IDLE;
			pend_byte_q  <= 8'h00;
			pend_valid_q <= 1'b0;
			len_q        <= '0;
		end else if (in_fire) begin
			mode_q       <= mode_d;
			pend_byte_q  <= pend_byte_d;
			pend_valid_q <= pend_valid_d;
			len_q        <= len_d;
		end
	end

	// result queue storage
	always_ff @(posedge clk) begin
		if (push_n != 2'd0) begin
			fifo_q[wr_ptr_q] <= r0_l;
		end
		if (push_n == 2'd2) begin
			fifo_q[wr_ptr_q + PTR_W'(1)] <= r1_l;
		end
	end

	// result queue pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			wr_ptr_q <= wr_ptr_q + PTR_W'(push_n);
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + PTR_W'(1);
			end
			count_q <= count_q + CNT_W'(push_n) - CNT_W'(pop);
		end
	end

	assign out_valid  = (count_q != '0);
	assign pop        = out_valid && out_ready;
	assign kind       = fifo_q[rd_ptr_q].kind;
	assign text_byte  = fifo_q[rd_ptr_q].text;
	assign token_end  = fifo_q[rd_ptr_q].tend;
	assign error_code = fifo_q[rd_ptr_q].err;
	assign last       = fifo_q[rd_ptr_q].last;

	// queue never overfills
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(FIFO_DEPTH))
		else $error("result queue overfilled");

	// fill count follows pushes and pops
	a_count_track: assert property (@(posedge clk) disable iff (!arst_n)
		1'b1 |=> (count_q == $past(count_q) + CNT_W'($past(push_n)) - CNT_W'($past(pop))))
		else $error("result queue count mismatch");

	// end of input always returns to idle with nothing held
	a_eoi_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(in_fire && end_of_input) |=> (mode_q == M_IDLE && !pend_valid_q && len_q == '0))
		else $error("end of input did not return to idle");

	// bytes in error drop produce no results
	a_err_silent: assert property (@(posedge clk) disable iff (!arst_n)
		(in_fire && mode_q == M_ERR) |-> (push_n == 2'd0))
		else $error("result produced during error drop");

	// token length stays within the split limit
	a_len_bound: assert property (@(posedge clk) disable iff (!arst_n)
		len_q <= LEN_W'(MAX_TOKEN_LEN))
		else $error("token length beyond limit");

endmodule

`default_nettype wire
